// File: hdl/srr_pkg.sv
`timescale 1ns / 1ps

package srr_pkg;

    // Cache geometry and predictor sizing.
    localparam int SETS     = 2048;
    localparam int WAYS     = 16;
    localparam int MAX_RRPV = 3;
    localparam int SIG_BITS = 12;

    localparam int SET_W       = $clog2(SETS);
    localparam int WAY_W       = $clog2(WAYS);
    localparam int RRPV_W      = $clog2(MAX_RRPV + 1);
    localparam int SIG_ENTRIES = 1 << SIG_BITS;

    // Signature counters are three bits wide and saturate at seven.
    localparam int CTR_W = 3;
    localparam logic [CTR_W-1:0] CTR_MAX   = 3'd7;
    localparam logic [CTR_W-1:0] CTR_RESET = 3'd1;

    // Fixed field widths of the stream words.
    localparam int IN_SET_W  = 11;
    localparam int IN_WAY_W  = 4;
    localparam int IN_PC_W   = 11;
    localparam int OUT_WAY_W = 4;
    localparam int OUT_PRI_W = 2;
    localparam int STRIDE_W  = 12;

    // The set index is split into an upper and a lower slice for the remainder unit.
    localparam int MOD_HI_W = 6;
    localparam int MOD_LO_W = IN_SET_W - MOD_HI_W;

    // Length of the clearing pass: the larger of the two memories.
    localparam int CLR_LEN = (SETS > SIG_ENTRIES) ? SETS : SIG_ENTRIES;
    localparam int CLR_W   = $clog2(CLR_LEN);

    typedef enum logic [1:0] {
        TYPE_LOAD      = 2'd0,
        TYPE_RFO       = 2'd1,
        TYPE_PREFETCH  = 2'd2,
        TYPE_WRITEBACK = 2'd3
    } access_type_t;

    typedef enum logic {
        CFG_PF_ALWAYS = 1'b0,
        CFG_STRIDE    = 1'b1
    } cfg_index_t;

    // State kept for one cache line.
    typedef struct packed {
        logic [SIG_BITS-1:0] sig;
        logic                reused;
        logic                pf;
        logic [RRPV_W-1:0]   rrpv;
    } line_t;

    typedef line_t [WAYS-1:0] row_t;

    localparam logic [RRPV_W-1:0] RRPV_MAX = RRPV_W'(MAX_RRPV);

    // Saturating counter steps.
    function automatic logic [CTR_W-1:0] ctr_inc(input logic [CTR_W-1:0] c);
        return (c == CTR_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [CTR_W-1:0] ctr_dec(input logic [CTR_W-1:0] c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

endpackage

// File: hdl/srr_ram.sv
`timescale 1ns / 1ps

module srr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/srr_sample.sv
`timescale 1ns / 1ps

module srr_sample
    import srr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [IN_SET_W-1:0] set_index,
    input  logic [STRIDE_W-1:0] stride,
    output logic                sampled
);

    logic [IN_SET_W-1:0] set_reg;
    logic [STRIDE_W-1:0] rem_reg;
    logic [STRIDE_W-1:0] rem_next;
    logic                fin_reg;

    // One restoring step: shift in a dividend bit, subtract the stride if it fits.
    function automatic logic [STRIDE_W-1:0] mod_step(
        input logic [STRIDE_W-1:0] rem,
        input logic                bit_in,
        input logic [STRIDE_W-1:0] div
    );
        logic [STRIDE_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, div})
        begin
            t = t - {1'b0, div};
        end
        return t[STRIDE_W-1:0];
    endfunction

    // The upper slice is reduced in the cycle of acceptance, the lower slice in the next.
    always_comb
    begin
        rem_next = rem_reg;
        if (start)
        begin
            rem_next = '0;
            for (int i = IN_SET_W - 1; i >= MOD_LO_W; i--)
            begin
                rem_next = mod_step(rem_next, set_index[i], stride);
            end
        end
        else if (fin_reg)
        begin
            for (int i = MOD_LO_W - 1; i >= 0; i--)
            begin
                rem_next = mod_step(rem_next, set_reg[i], stride);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg <= 1'b0;
        end
        else
        begin
            fin_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            set_reg <= set_index;
        end
        rem_reg <= rem_next;
    end

    // A zero stride samples set zero alone.
    assign sampled = (stride == '0) ? (set_reg == '0) : (rem_reg == '0);

endmodule

// File: hdl/ship_rrip_cache_replacement.sv
`timescale 1ns / 1ps

// Replacement controller for a set-associative cache on re-reference prediction
// with signature based insertion.
// The slave stream carries one cache access per word: tdata holds set, hit way,
// PC bits and the training draw, tuser holds the hit flag and the access type.
// The master stream returns one word per access with the victim or hit way and
// the priority written for the line; tuser flags a fill.
// An access runs in steps: the set's line state is read from the row memory, the
// chosen line's signature counter is read from the counter memory, and then the
// row and, if trained, the counter are written back while the result is loaded into
// the output register. The next word can be taken in the following cycle; a new
// word is not taken until the last one has been written back.
// After reset a clearing pass initialises both memories; no word
// is taken during it, though configuration writes are. If the receiver stalls,
// the result waits in the output register, one further access is accepted and
// completes its reads, and it then waits before its write-back until the output
// register is free.
module ship_rrip_cache_replacement
    import srr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // set_index, hit_way, pc_low, train_draw, zero fill
    input  logic [2:0]          s_tuser,   // hit, access_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // victim_way, insert_priority, zero fill
    output logic                m_tuser,   // filled
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [STRIDE_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ROW   = 4'b0100,
        S_CTR   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Input word fields.
    logic [IN_SET_W-1:0] f_set;
    logic [IN_WAY_W-1:0] f_way;
    logic [IN_PC_W-1:0]  f_pc;
    logic                f_draw;
    logic                f_hit;
    access_type_t        f_type;

    assign f_set  = s_tdata[10:0];
    assign f_way  = s_tdata[14:11];
    assign f_pc   = s_tdata[25:15];
    assign f_draw = s_tdata[26];
    assign f_hit  = s_tuser[0];
    assign f_type = access_type_t'(s_tuser[2:1]);

    logic [SET_W-1:0]    set_w;
    logic [SIG_BITS-1:0] new_sig_w;
    logic                accept;

    assign set_w     = SET_W'(f_set);
    assign new_sig_w = SIG_BITS'({f_pc, (f_type == TYPE_PREFETCH)});
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;

    // Configuration registers.
    logic                pf_always_reg;
    logic [STRIDE_W-1:0] stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pf_always_reg <= 1'b0;
            stride_reg    <= STRIDE_W'(65);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PF_ALWAYS: pf_always_reg <= cfg_data[0];
                CFG_STRIDE:    stride_reg    <= cfg_data;
                default:       pf_always_reg <= pf_always_reg;
            endcase
        end
    end

    // Accepted access, held until the next word is taken.
    logic [SET_W-1:0]    in_set_reg;
    logic                in_hit_reg;
    logic [WAY_W-1:0]    in_way_reg;
    access_type_t        in_type_reg;
    logic                in_draw_reg;
    logic [SIG_BITS-1:0] new_sig_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_set_reg  <= set_w;
            in_hit_reg  <= f_hit;
            in_way_reg  <= WAY_W'(f_way);
            in_type_reg <= f_type;
            in_draw_reg <= f_draw;
            new_sig_reg <= new_sig_w;
        end
    end

    // Sampled set test runs alongside the memory reads.
    logic sampled;

    srr_sample u_sample (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .set_index (IN_SET_W'(set_w)),
        .stride    (stride_reg),
        .sampled   (sampled)
    );

    // Clearing pass counter.
    logic [CLR_W-1:0] clr_cnt_reg;
    logic             clr_row;

    assign clr_row = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(SETS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (state_reg == S_CLEAR)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Memories.
    row_t                row_rdata;
    row_t                row_wdata;
    logic                row_we;
    logic [SET_W-1:0]    row_waddr;
    logic [CTR_W-1:0]    ctr_rdata;
    logic [CTR_W-1:0]    ctr_wdata;
    logic                ctr_we;
    logic [SIG_BITS-1:0] ctr_waddr;
    logic                ctr_re;
    logic [SIG_BITS-1:0] ctr_raddr;

    srr_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (accept),
        .raddr (set_w),
        .rdata (row_rdata)
    );

    srr_ram #(
        .WIDTH (CTR_W),
        .DEPTH (SIG_ENTRIES)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .re    (ctr_re),
        .raddr (ctr_raddr),
        .rdata (ctr_rdata)
    );

    // Victim search: the first way holding the highest RRPV; on a miss the set ages by the gap.
    logic [RRPV_W-1:0] top_rrpv;
    logic [RRPV_W-1:0] age_add;
    logic [WAY_W-1:0]  victim;
    row_t              row_aged;
    logic [WAY_W-1:0]  way_sel;
    line_t             line_sel;

    always_comb
    begin
        top_rrpv = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (row_rdata[w].rrpv > top_rrpv)
            begin
                top_rrpv = row_rdata[w].rrpv;
            end
        end
        age_add = (top_rrpv < RRPV_MAX) ? (RRPV_MAX - top_rrpv) : '0;
        victim = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row_rdata[w].rrpv == top_rrpv)
            begin
                victim = WAY_W'(w);
            end
        end
        row_aged = row_rdata;
        if (!in_hit_reg)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                row_aged[w].rrpv = row_rdata[w].rrpv + age_add;
            end
        end
        way_sel  = in_hit_reg ? in_way_reg : victim;
        line_sel = row_aged[way_sel];
    end

    // Row and line captured after the row read.
    row_t             row_reg;
    line_t            line_reg;
    logic [WAY_W-1:0] way_reg;
    logic [CTR_W-1:0] newctr_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROW)
        begin
            row_reg    <= row_aged;
            line_reg   <= line_sel;
            way_reg    <= way_sel;
            newctr_reg <= ctr_rdata;
        end
    end

    // Counter reads: the new signature on acceptance, the line's signature next.
    assign ctr_re    = accept || (state_reg == S_ROW);
    assign ctr_raddr = (state_reg == S_ROW) ? line_sel.sig : new_sig_w;

    // Update of the chosen line and its signature counter.
    line_t             line_upd;
    logic [CTR_W-1:0]  ctr_upd;
    logic              ctr_upd_en;
    logic [CTR_W-1:0]  ctr_new;
    logic [RRPV_W-1:0] pri;
    logic              is_pf;
    logic              is_wb;

    always_comb
    begin
        is_pf      = (in_type_reg == TYPE_PREFETCH);
        is_wb      = (in_type_reg == TYPE_WRITEBACK);
        line_upd   = line_reg;
        ctr_upd    = ctr_rdata;
        ctr_upd_en = 1'b0;
        ctr_new    = newctr_reg;
        pri        = line_reg.rrpv;
        if (in_hit_reg)
        begin
            if (!is_wb)
            begin
                if (is_pf && line_reg.pf)
                begin
                    if (sampled && (in_draw_reg || pf_always_reg))
                    begin
                        ctr_upd         = ctr_inc(ctr_rdata);
                        ctr_upd_en      = 1'b1;
                        line_upd.reused = 1'b1;
                    end
                end
                else
                begin
                    line_upd.rrpv = line_reg.pf ? RRPV_MAX : '0;
                    line_upd.pf   = 1'b0;
                    if (sampled && !line_reg.reused)
                    begin
                        ctr_upd         = ctr_inc(ctr_rdata);
                        ctr_upd_en      = 1'b1;
                        line_upd.reused = 1'b1;
                    end
                end
            end
            pri = line_upd.rrpv;
        end
        else
        begin
            if (sampled)
            begin
                ctr_upd         = line_reg.reused ? ctr_inc(ctr_rdata) : ctr_dec(ctr_rdata);
                ctr_upd_en      = 1'b1;
                line_upd.reused = 1'b0;
                line_upd.sig    = new_sig_reg;
                // The evicted signature may be the one being inserted.
                if (new_sig_reg == line_reg.sig)
                begin
                    ctr_new = ctr_upd;
                end
            end
            line_upd.pf = is_pf;
            if (is_wb || (ctr_new == '0))
            begin
                pri = RRPV_MAX;
            end
            else if (ctr_new == CTR_MAX)
            begin
                pri = is_pf ? RRPV_W'(1) : '0;
            end
            else
            begin
                pri = RRPV_MAX - 1'b1;
            end
            line_upd.rrpv = pri;
        end
    end

    // Write-back happens once the output register can take the result.
    logic out_valid_reg;
    logic fire;

    assign fire = (state_reg == S_CTR) && (!out_valid_reg || m_tready);

    line_t clr_line;

    always_comb
    begin
        clr_line      = '0;
        clr_line.rrpv = RRPV_MAX;
        row_wdata = row_reg;
        row_wdata[way_reg] = line_upd;
        row_we    = fire;
        row_waddr = in_set_reg;
        ctr_wdata = ctr_upd;
        ctr_we    = fire && ctr_upd_en;
        ctr_waddr = line_reg.sig;
        if (state_reg == S_CLEAR)
        begin
            row_wdata = {WAYS{clr_line}};
            row_we    = clr_row;
            row_waddr = clr_cnt_reg[SET_W-1:0];
            ctr_wdata = CTR_RESET;
            ctr_we    = 1'b1;
            ctr_waddr = clr_cnt_reg[SIG_BITS-1:0];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == CLR_W'(CLR_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                state_next = S_CTR;
            end
            S_CTR:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Output word register.
    logic [OUT_WAY_W-1:0] out_way_reg;
    logic                 out_filled_reg;
    logic [OUT_PRI_W-1:0] out_pri_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_way_reg    <= OUT_WAY_W'(way_reg);
            out_filled_reg <= !in_hit_reg;
            out_pri_reg    <= OUT_PRI_W'(pri);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_pri_reg, out_way_reg};
    assign m_tuser  = out_filled_reg;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import srr_pkg::*;

    // One cache access as it travels on the slave stream.
    typedef struct {
        logic [IN_SET_W-1:0] set_index;
        logic                hit;
        logic [IN_WAY_W-1:0] hit_way;
        access_type_t        access_type;
        logic [IN_PC_W-1:0]  pc_low;
        logic                train_draw;
    } access_t;

    // One replacement decision as it comes back on the master stream.
    typedef struct {
        logic [OUT_WAY_W-1:0] victim_way;
        logic                 filled;
        logic [OUT_PRI_W-1:0] insert_priority;
    } decision_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata = '0;   // set_index, hit_way, pc_low, train_draw, zero fill
    logic [2:0]          s_tuser = '0;   // hit, access_type
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;        // victim_way, insert_priority, zero fill
    logic                m_tuser;        // filled
    logic                cfg_we = 1'b0;
    cfg_index_t          cfg_index = CFG_PF_ALWAYS;
    logic [STRIDE_W-1:0] cfg_data = '0;

    // Shadow copy of the replacement state and the registers.
    logic [RRPV_W-1:0]   shadow_rrpv [SETS*WAYS];
    bit                  line_prefetched [SETS*WAYS];
    bit                  line_reused [SETS*WAYS];
    logic [SIG_BITS-1:0] shadow_sig [SETS*WAYS];
    logic [CTR_W-1:0]    sig_ctr [SIG_ENTRIES];
    bit                  pf_train_always;
    logic [STRIDE_W-1:0] sample_stride;

    access_t   access_backlog[$];
    decision_t expected_decisions[$];
    access_t   word_on_bus;
    int        failures = 0;
    bit        quiet_tail = 1'b0;

    // Sender side bookkeeping.
    int        send_gap;

    // Receiver side bookkeeping.
    int        stall_left;
    int        hold_left;
    bit        hold_done;
    int        decisions_seen;

    ship_rrip_cache_replacement u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Saturating steps of a signature counter.
    function automatic void sig_ctr_up(input logic [SIG_BITS-1:0] sig);
        if (sig_ctr[sig] != CTR_MAX)
            sig_ctr[sig] = sig_ctr[sig] + 1'b1;
    endfunction

    function automatic void sig_ctr_down(input logic [SIG_BITS-1:0] sig);
        if (sig_ctr[sig] != '0)
            sig_ctr[sig] = sig_ctr[sig] - 1'b1;
    endfunction

    // Applies one access to the shadow state and returns the decision it makes.
    function automatic decision_t ship_replace(input access_t a);
        int unsigned         set_no;
        int unsigned         way;
        int unsigned         base;
        int unsigned         idx;
        int unsigned         top;
        int                  w;
        bit                  sampled;
        bit                  is_pf;
        logic [SIG_BITS-1:0] new_sig;
        logic [CTR_W-1:0]    ctr;
        logic [RRPV_W-1:0]   pri;
        decision_t           d;
        set_no  = a.set_index % SETS;
        base    = set_no * WAYS;
        is_pf   = (a.access_type == TYPE_PREFETCH);
        sampled = (sample_stride == '0) ? (set_no == 0) : ((set_no % sample_stride) == 0);
        if (a.hit)
        begin
            way = a.hit_way % WAYS;
            idx = base + way;
            if (a.access_type != TYPE_WRITEBACK)
            begin
                if (is_pf && line_prefetched[idx])
                begin
                    // A prefetch on a prefetched line only trains, by chance or when training is forced.
                    if (sampled && (a.train_draw || pf_train_always))
                    begin
                        sig_ctr_up(shadow_sig[idx]);
                        line_reused[idx] = 1'b1;
                    end
                end
                else
                begin
                    // Promote, unless a demand use of a prefetched line demotes it.
                    shadow_rrpv[idx] = line_prefetched[idx] ? RRPV_MAX : '0;
                    line_prefetched[idx] = 1'b0;
                    if (sampled && !line_reused[idx])
                    begin
                        sig_ctr_up(shadow_sig[idx]);
                        line_reused[idx] = 1'b1;
                    end
                end
            end
            d.victim_way      = OUT_WAY_W'(way);
            d.filled          = 1'b0;
            d.insert_priority = OUT_PRI_W'(shadow_rrpv[idx]);
            return d;
        end
        // Age the set until some way is at the distant value, then take the lowest such way.
        top = 0;
        for (w = 0; w < WAYS; w++)
            if (shadow_rrpv[base + w] > top)
                top = shadow_rrpv[base + w];
        if (top < MAX_RRPV)
            for (w = 0; w < WAYS; w++)
                shadow_rrpv[base + w] = shadow_rrpv[base + w] + RRPV_W'(MAX_RRPV - top);
        way = 0;
        for (w = WAYS - 1; w >= 0; w--)
            if (shadow_rrpv[base + w] >= MAX_RRPV)
                way = w;
        idx = base + way;
        new_sig = SIG_BITS'((int'(a.pc_low) << 1) + (is_pf ? 1 : 0));
        // Sampled sets learn from the evicted line and remember the new signature.
        if (sampled)
        begin
            if (line_reused[idx])
                sig_ctr_up(shadow_sig[idx]);
            else
                sig_ctr_down(shadow_sig[idx]);
            line_reused[idx] = 1'b0;
            shadow_sig[idx]  = new_sig;
        end
        line_prefetched[idx] = is_pf;
        ctr = sig_ctr[new_sig];
        if (a.access_type == TYPE_WRITEBACK || ctr == '0)
            pri = RRPV_MAX;
        else if (ctr == CTR_MAX)
            pri = is_pf ? RRPV_W'(1) : RRPV_W'(0);
        else
            pri = RRPV_MAX - 1'b1;
        shadow_rrpv[idx]  = pri;
        d.victim_way      = OUT_WAY_W'(way);
        d.filled          = 1'b1;
        d.insert_priority = OUT_PRI_W'(pri);
        return d;
    endfunction

    // Sender: offers queued words, with random gaps after some of them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_decisions.push_back(ship_replace(word_on_bus));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (access_backlog.size() != 0)
                begin
                    word_on_bus = access_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, word_on_bus.train_draw, word_on_bus.pc_low,
                                 word_on_bus.hit_way, word_on_bus.set_index};
                    s_tuser  <= {word_on_bus.access_type, word_on_bus.hit};
                    if (!quiet_tail && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 8);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off of the receiver, once enough results have come back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && decisions_seen >= 40)
        begin
            hold_done <= 1'b1;
            hold_left <= 150;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks each result word and stalls in bursts.
    always @(posedge clk or negedge rst_n)
    begin
        decision_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            decisions_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                decisions_seen++;
                if (expected_decisions.size() == 0)
                begin
                    $error("result word with no access outstanding");
                    failures++;
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    if (m_tdata[3:0] !== want.victim_way)
                    begin
                        $error("victim_way expected %0d actual %0d",
                               want.victim_way, m_tdata[3:0]);
                        failures++;
                    end
                    if (m_tuser !== want.filled)
                    begin
                        $error("filled expected %0d actual %0d", want.filled, m_tuser);
                        failures++;
                    end
                    if (m_tdata[5:4] !== want.insert_priority)
                    begin
                        $error("insert_priority expected %0d actual %0d",
                               want.insert_priority, m_tdata[5:4]);
                        failures++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_access(input logic [IN_SET_W-1:0] set_index, input logic hit,
                                input logic [IN_WAY_W-1:0] hit_way, input access_type_t kind,
                                input logic [IN_PC_W-1:0] pc_low, input logic train_draw);
        access_t a;
        a.set_index   = set_index;
        a.hit         = hit;
        a.hit_way     = hit_way;
        a.access_type = kind;
        a.pc_low      = pc_low;
        a.train_draw  = train_draw;
        access_backlog.push_back(a);
    endtask

    // Mostly a few hot sets and PCs so that lines get reused and counters saturate.
    task automatic queue_random_accesses(input int count);
        int unsigned hot_sets [6];
        int unsigned hot_pcs [4];
        int unsigned pick;
        int          n;
        access_type_t kind;
        hot_sets = '{0, 1, 3, 6, 65, 2047};
        hot_pcs  = '{0, 9, 1024, 2047};
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                kind = TYPE_LOAD;
            else if (pick < 55)
                kind = TYPE_RFO;
            else if (pick < 85)
                kind = TYPE_PREFETCH;
            else
                kind = TYPE_WRITEBACK;
            queue_access(
                ($urandom_range(0, 99) < 85) ? IN_SET_W'(hot_sets[$urandom_range(0, 5)])
                                             : IN_SET_W'($urandom_range(0, 2047)),
                1'($urandom_range(0, 1)),
                IN_WAY_W'($urandom_range(0, 15)),
                kind,
                ($urandom_range(0, 99) < 75) ? IN_PC_W'(hot_pcs[$urandom_range(0, 3)])
                                             : IN_PC_W'($urandom_range(0, 2047)),
                1'($urandom_range(0, 1)));
        end
    endtask

    // Returns once every queued word has been taken and answered.
    task automatic wait_drained();
        while (access_backlog.size() != 0 || s_tvalid || expected_decisions.size() != 0)
            @(negedge clk);
    endtask

    // Register write, mirrored into the shadow copy; only used while the block is idle.
    task automatic write_reg(input cfg_index_t idx, input logic [STRIDE_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_PF_ALWAYS)
            pf_train_always = value[0];
        else
            sample_stride = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic pf_always, input logic [STRIDE_W-1:0] stride_value,
                             input int count);
        write_reg(CFG_PF_ALWAYS, STRIDE_W'(pf_always));
        write_reg(CFG_STRIDE, stride_value);
        queue_random_accesses(count);
        wait_drained();
    endtask

    // Stimulus sequence and end of run.
    initial
    begin
        int i;
        for (i = 0; i < SETS * WAYS; i++)
        begin
            shadow_rrpv[i]     = RRPV_MAX;
            line_prefetched[i] = 1'b0;
            line_reused[i]     = 1'b0;
            shadow_sig[i]      = '0;
        end
        for (i = 0; i < SIG_ENTRIES; i++)
            sig_ctr[i] = CTR_RESET;
        pf_train_always = 1'b0;
        sample_stride   = STRIDE_W'(65);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed accesses under the reset settings: sampled sets 0, 65 and 2015.
        queue_access(11'd0,    1'b0, 4'd0,  TYPE_LOAD,      11'd0,    1'b0);
        queue_access(11'd0,    1'b0, 4'd0,  TYPE_PREFETCH,  11'd2047, 1'b0);
        queue_access(11'd0,    1'b1, 4'd0,  TYPE_LOAD,      11'd0,    1'b0);
        queue_access(11'd0,    1'b1, 4'd1,  TYPE_PREFETCH,  11'd5,    1'b0);
        queue_access(11'd0,    1'b1, 4'd1,  TYPE_PREFETCH,  11'd5,    1'b1);
        queue_access(11'd0,    1'b1, 4'd1,  TYPE_RFO,       11'd5,    1'b0);
        queue_access(11'd0,    1'b1, 4'd0,  TYPE_WRITEBACK, 11'd7,    1'b1);
        queue_access(11'd0,    1'b0, 4'd9,  TYPE_WRITEBACK, 11'd7,    1'b0);
        queue_access(11'd2047, 1'b0, 4'd15, TYPE_WRITEBACK, 11'd2047, 1'b1);
        queue_access(11'd2047, 1'b1, 4'd15, TYPE_WRITEBACK, 11'd2047, 1'b1);
        queue_access(11'd2047, 1'b1, 4'd0,  TYPE_LOAD,      11'd2047, 1'b1);
        queue_access(11'd2015, 1'b0, 4'd3,  TYPE_RFO,       11'd1024, 1'b1);
        queue_access(11'd2015, 1'b1, 4'd0,  TYPE_RFO,       11'd1024, 1'b0);
        queue_access(11'd65,   1'b0, 4'd0,  TYPE_PREFETCH,  11'd9,    1'b1);
        queue_access(11'd65,   1'b1, 4'd0,  TYPE_LOAD,      11'd9,    1'b0);
        queue_access(11'd65,   1'b1, 4'd0,  TYPE_LOAD,      11'd9,    1'b0);
        queue_access(11'd1,    1'b1, 4'd15, TYPE_PREFETCH,  11'd0,    1'b1);
        queue_access(11'd1,    1'b0, 4'd0,  TYPE_LOAD,      11'd0,    1'b0);
        wait_drained();

        // Every set sampled, then only set 0 by a zero stride and by the widest one, then every third set.
        run_phase(1'b1, STRIDE_W'(1), 160);
        run_phase(1'b0, STRIDE_W'(0), 120);
        run_phase(1'b1, STRIDE_W'(4095), 100);
        run_phase(1'b0, STRIDE_W'(3), 130);

        // Final stretch at full rate on both sides.
        quiet_tail = 1'b1;
        run_phase(1'b1, STRIDE_W'(2048), 90);
        repeat (10) @(negedge clk);

        if (failures == 0 && expected_decisions.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog covering the clearing pass, the long stall and every burst of idling.
    initial
    begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
